[rtl/hts_pkg.sv]
// Shared constants, types and the arctangent table for the haversine trip distance block.
package hts_pkg;

    localparam int CORDIC_ITERATIONS = 30;
    localparam int TOTAL_WIDTH       = 48;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

    // CORDIC datapath width: Q30 values plus gain growth and sign
    localparam int CW = 34;

    // square root unit: Q60 radicand, Q30 root
    localparam int SQ_IN_W  = 61;
    localparam int SQ_RES_W = 62;
    localparam int SQ_OUT_W = 31;

    localparam logic [CW-1:0]          GAIN_Q30     = 34'd652032874;
    localparam logic [31:0]            DEG7_TO_BAM  = 32'd2562047788;
    // pi/2 in Q32 less 2^32; the 2^32 part is added back as a shift
    localparam logic [31:0]            PI_HALF_LO   = 32'd2451551556;
    localparam logic [22:0]            RADIUS_RESET = 23'd6371000;
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX    = '1;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctl;

    // atan(2^-i) in Q30, rounded
    function automatic logic signed [CW-1:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic signed [CW-1:0] v;
        unique case (int'(idx))
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            31: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/hts_cordic.sv]
// Iterative CORDIC unit, rotation and vectoring mode, one micro-rotation per cycle.
module hts_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hts_pkg::t_cordic_ctl             i_ctl,
    input  logic signed [hts_pkg::CW-1:0]    i_x,
    input  logic signed [hts_pkg::CW-1:0]    i_y,
    input  logic signed [hts_pkg::CW-1:0]    i_z,
    output logic                             o_done,
    output logic signed [hts_pkg::CW-1:0]    o_x,
    output logic signed [hts_pkg::CW-1:0]    o_y,
    output logic signed [hts_pkg::CW-1:0]    o_z
);

    logic                              r_busy;
    logic                              r_done;
    logic                              r_vec;
    logic [hts_pkg::ITER_W-1:0]        r_cnt;
    logic signed [hts_pkg::CW-1:0]     r_x, r_y, r_z;
    logic signed [hts_pkg::CW-1:0]     n_x, n_y, n_z;
    logic signed [hts_pkg::CW-1:0]     dx, dy, ang;
    logic                              pos;
    logic                              last;

    assign dx   = r_y >>> r_cnt;
    assign dy   = r_x >>> r_cnt;
    assign ang  = hts_pkg::atan_q30(r_cnt);
    assign last = (r_cnt == hts_pkg::ITER_W'(hts_pkg::CORDIC_ITERATIONS - 1));

    // vectoring drives y toward zero (y > 0 turns clockwise), rotation drives z
    assign pos = r_vec ? (r_y[hts_pkg::CW-1] || (r_y == '0)) : !r_z[hts_pkg::CW-1];

    always_comb begin
        if (pos) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_ctl.vectoring;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

[rtl/hts_isqrt.sv]
// Digit-by-digit floor square root, one root bit per cycle.
module hts_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hts_pkg::SQ_IN_W-1:0]    i_n,
    output logic                           o_done,
    output logic [hts_pkg::SQ_OUT_W-1:0]   o_root
);

    logic                            r_busy;
    logic                            r_done;
    logic [hts_pkg::SQ_IN_W-1:0]     r_n;
    logic [hts_pkg::SQ_RES_W-1:0]    r_res;
    logic [hts_pkg::SQ_RES_W-1:0]    r_bit;
    logic [hts_pkg::SQ_RES_W-1:0]    trial;
    logic [hts_pkg::SQ_RES_W-1:0]    diff;
    logic                            take;

    assign trial = r_res + r_bit;
    assign take  = ({1'b0, r_n} >= trial);
    assign diff  = {1'b0, r_n} - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= hts_pkg::SQ_RES_W'(1) << (hts_pkg::SQ_IN_W - 1);
        end else if (r_busy) begin
            if (take) begin
                r_n   <= diff[hts_pkg::SQ_IN_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[hts_pkg::SQ_OUT_W-1:0];

endmodule

[rtl/haversine_trip_distance.sv]
// One segment is worked on at a time: no new input is taken until the current result is
// registered on the output. The shared CORDIC unit runs five passes (the vectoring pass is
// skipped when a comes out zero) and the root unit two passes of 31 steps for every segment,
// one step per cycle. The next item is taken while a finished result waits on the output.
// Reset (i_rst_n low, synchronous) clears the trip total, the saturation flag and the
// sequencer, and sets the earth radius to 6371000 m.
module haversine_trip_distance (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [22:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_trip_start,
    input  logic signed [30:0]  i_lat_first,
    input  logic signed [31:0]  i_lon_first,
    input  logic signed [30:0]  i_lat_second,
    input  logic signed [31:0]  i_lon_second,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [34:0]         o_segment_mm,
    output logic [47:0]         o_total_mm,
    output logic                o_total_saturated
);

    localparam int TW = hts_pkg::TOTAL_WIDTH;
    localparam int CW = hts_pkg::CW;

    localparam logic [1:0] ANG_DLAT  = 2'd0;
    localparam logic [1:0] ANG_DLON  = 2'd1;
    localparam logic [1:0] ANG_LAT_A = 2'd2;
    localparam logic [1:0] ANG_LAT_B = 2'd3;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_DIFF = 22'h000002,
        S_BAM  = 22'h000004,
        S_ANG  = 22'h000008,
        S_FLIP = 22'h000010,
        S_ZMUL = 22'h000020,
        S_ZSET = 22'h000040,
        S_ROT  = 22'h000080,
        S_M0   = 22'h000100,
        S_M1   = 22'h000200,
        S_M2   = 22'h000400,
        S_M3   = 22'h000800,
        S_M4   = 22'h001000,
        S_SQX0 = 22'h002000,
        S_SQX1 = 22'h004000,
        S_SQY0 = 22'h008000,
        S_SQY1 = 22'h010000,
        S_VEC0 = 22'h020000,
        S_VEC1 = 22'h040000,
        S_SEG0 = 22'h080000,
        S_SEG1 = 22'h100000,
        S_DONE = 22'h200000
    } t_state;

    t_state r_state, n_state;

    logic [22:0]          r_radius;
    logic [1:0]           r_k;
    logic                 r_start;
    logic signed [30:0]   r_lat_a, r_lat_b;
    logic signed [31:0]   r_lon_a, r_lon_b;
    logic [32:0]          r_m;
    logic                 r_vneg;
    logic [31:0]          r_ang;
    logic                 r_flip, r_neg;
    logic [30:0]          r_mag;
    logic signed [65:0]   r_prod;
    logic signed [32:0]   r_s1, r_s2, r_ca, r_cb, r_t, r_u;
    logic signed [65:0]   r_acc;
    logic [60:0]          r_a;
    logic [30:0]          r_sx, r_sy;
    logic [32:0]          r_r1000;
    logic [30:0]          r_half;
    logic [34:0]          r_seg;
    logic [34:0]          r_out_seg;
    logic                 r_out_valid;
    logic [TW-1:0]        r_total;
    logic                 r_sat;

    logic                 accept;
    logic                 out_free;
    logic signed [32:0]   op_a, op_b;
    logic signed [65:0]   mul_p;
    logic signed [33:0]   v;
    logic [33:0]          v_abs;
    logic [63:0]          bam_rnd;
    logic [31:0]          ang_u;
    logic [31:0]          ang_s, ang_q, a2, mag_w;
    logic [63:0]          z_rnd;
    logic [CW-1:0]        z_u;
    logic signed [CW-1:0] z_init;
    logic signed [CW-1:0] rx, ry;
    logic signed [65:0]   rnd30;
    logic signed [65:0]   a_sum;
    logic [63:0]          seg_sum;
    logic [TW-1:0]        tot_base;
    logic                 sat_base;

    hts_pkg::t_cordic_ctl cordic_ctl;
    logic signed [CW-1:0] c_x_in, c_y_in, c_z_in;
    logic                 c_done;
    logic signed [CW-1:0] c_x, c_y, c_z;
    logic                 sq_start;
    logic [60:0]          sq_n;
    logic                 sq_done;
    logic [30:0]          sq_root;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // shared multiplier, registered
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_BAM: begin
                op_a = {1'b0, r_m[31:0]};
                op_b = {1'b0, hts_pkg::DEG7_TO_BAM};
            end
            S_ZMUL: begin
                op_a = {2'b0, r_mag};
                op_b = {1'b0, hts_pkg::PI_HALF_LO};
            end
            S_M0: begin
                op_a = r_s2;
                op_b = r_ca;
            end
            S_M1: begin
                op_a = r_s2;
                op_b = r_cb;
            end
            S_M2: begin
                op_a = r_s1;
                op_b = r_s1;
            end
            S_M3: begin
                op_a = r_t;
                op_b = r_u;
            end
            S_SEG0: begin
                op_a = {1'b0, r_r1000[31:0]};
                op_b = {2'b0, r_half};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_p = op_a * op_b;

    // angle source for the current pass
    always_comb begin
        unique case (r_k)
            ANG_DLAT:  v = 34'(r_lat_b) - 34'(r_lat_a);
            ANG_DLON:  v = 34'(r_lon_b) - 34'(r_lon_a);
            ANG_LAT_A: v = 34'(r_lat_a) + 34'(r_lat_a);
            ANG_LAT_B: v = 34'(r_lat_b) + 34'(r_lat_b);
            default:   v = '0;
        endcase
    end

    assign v_abs = v[33] ? (34'd0 - v) : v;

    // binary angle, then fold into [-90, 90) degrees
    assign bam_rnd = r_prod[63:0] + 64'h8000_0000;
    assign ang_u   = bam_rnd[63:32] + (r_m[32] ? hts_pkg::DEG7_TO_BAM : 32'd0);
    assign ang_s   = r_vneg ? (32'd0 - r_ang) : r_ang;
    assign ang_q   = ang_s + 32'h4000_0000;
    assign a2      = ang_q[31] ? (ang_s ^ 32'h8000_0000) : ang_s;
    assign mag_w   = a2[31] ? (32'd0 - a2) : a2;

    assign z_rnd  = r_prod[63:0] + 64'h8000_0000;
    assign z_u    = {2'b0, z_rnd[63:32]} + {3'b0, r_mag};
    assign z_init = r_neg ? (CW'(0) - z_u) : z_u;

    assign rx = r_flip ? (CW'(0) - c_x) : c_x;
    assign ry = r_flip ? (CW'(0) - c_y) : c_y;

    assign rnd30   = r_prod + (66'sd1 <<< 29);
    assign a_sum   = r_acc + r_prod;
    assign seg_sum = r_prod[63:0] + (r_r1000[32] ? {1'b0, r_half, 32'b0} : 64'd0)
                   + 64'h1000_0000;

    assign tot_base = r_start ? '0 : r_total;
    assign sat_base = r_start ? 1'b0 : r_sat;

    // CORDIC and root unit launches
    assign cordic_ctl.start     = (r_state == S_ZSET) || ((r_state == S_VEC0) && (r_sy != '0));
    assign cordic_ctl.vectoring = (r_state == S_VEC0);
    assign c_x_in = (r_state == S_ZSET) ? hts_pkg::GAIN_Q30 : {3'b0, r_sx};
    assign c_y_in = (r_state == S_ZSET) ? CW'(0) : {3'b0, r_sy};
    assign c_z_in = (r_state == S_ZSET) ? z_init : CW'(0);

    assign sq_start = (r_state == S_SQX0) || (r_state == S_SQY0);
    assign sq_n     = (r_state == S_SQX0) ? ((61'd1 << 60) - r_a) : r_a;

    hts_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cordic_ctl),
        .i_x     (c_x_in),
        .i_y     (c_y_in),
        .i_z     (c_z_in),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    hts_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_DIFF;
            S_DIFF: n_state = S_BAM;
            S_BAM:  n_state = S_ANG;
            S_ANG:  n_state = S_FLIP;
            S_FLIP: n_state = S_ZMUL;
            S_ZMUL: n_state = S_ZSET;
            S_ZSET: n_state = S_ROT;
            S_ROT: begin
                if (c_done) n_state = (r_k == ANG_LAT_B) ? S_M0 : S_DIFF;
            end
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_SQX0;
            S_SQX0: n_state = S_SQX1;
            S_SQX1: if (sq_done) n_state = S_SQY0;
            S_SQY0: n_state = S_SQY1;
            S_SQY1: if (sq_done) n_state = S_VEC0;
            S_VEC0: n_state = (r_sy == '0) ? S_SEG0 : S_VEC1;
            S_VEC1: if (c_done) n_state = S_SEG0;
            S_SEG0: n_state = S_SEG1;
            S_SEG1: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= hts_pkg::RADIUS_RESET;
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_radius <= i_cfg_wdata;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (TW'(r_seg) >= (hts_pkg::TOTAL_MAX - tot_base)) begin
                    r_total <= hts_pkg::TOTAL_MAX;
                    r_sat   <= 1'b1;
                end else begin
                    r_total <= tot_base + TW'(r_seg);
                    r_sat   <= sat_base;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (accept) begin
            r_start <= i_trip_start;
            r_lat_a <= i_lat_first;
            r_lon_a <= i_lon_first;
            r_lat_b <= i_lat_second;
            r_lon_b <= i_lon_second;
            r_k     <= ANG_DLAT;
        end
        unique case (r_state)
            S_DIFF: begin
                r_m    <= v_abs[32:0];
                r_vneg <= v[33];
            end
            S_ANG: r_ang <= ang_u;
            S_FLIP: begin
                r_flip <= ang_q[31];
                r_neg  <= a2[31];
                r_mag  <= mag_w[30:0];
            end
            S_ROT: begin
                if (c_done) begin
                    unique case (r_k)
                        ANG_DLAT:  r_s1 <= 33'(ry);
                        ANG_DLON:  r_s2 <= 33'(ry);
                        ANG_LAT_A: r_ca <= 33'(rx);
                        ANG_LAT_B: r_cb <= 33'(rx);
                        default:   r_s1 <= 33'(ry);
                    endcase
                    r_k <= r_k + 2'd1;
                end
            end
            S_M1: r_t   <= 33'(rnd30 >>> 30);
            S_M2: r_u   <= 33'(rnd30 >>> 30);
            S_M3: r_acc <= r_prod;
            S_M4: begin
                // clamp a to [0, 1] in Q60
                if (a_sum[65]) begin
                    r_a <= '0;
                end else if (a_sum > (66'sd1 <<< 60)) begin
                    r_a <= 61'd1 << 60;
                end else begin
                    r_a <= a_sum[60:0];
                end
            end
            S_SQX0: r_r1000 <= (33'(r_radius) << 10) - (33'(r_radius) << 4)
                             - (33'(r_radius) << 3);
            S_SQX1: if (sq_done) r_sx <= sq_root;
            S_SQY1: if (sq_done) r_sy <= sq_root;
            S_VEC0: if (r_sy == '0) r_half <= '0;
            S_VEC1: if (c_done) r_half <= c_z[CW-1] ? 31'd0 : c_z[30:0];
            S_SEG1: r_seg <= seg_sum[63:29];
            S_DONE: if (out_free) r_out_seg <= r_seg;
            default: ;
        endcase
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_segment_mm      = r_out_seg;
    assign o_total_mm        = 48'(r_total);
    assign o_total_saturated = r_sat;

endmodule

[rtl/hts_checker.sv]
// Port-level checker for the haversine trip distance block, bound to the top level.
module hts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [22:0]         i_cfg_wdata,
    input logic                i_valid,
    input logic                o_stall,
    input logic                i_trip_start,
    input logic signed [30:0]  i_lat_first,
    input logic signed [31:0]  i_lon_first,
    input logic signed [30:0]  i_lat_second,
    input logic signed [31:0]  i_lon_second,
    input logic                o_valid,
    input logic                i_stall,
    input logic [34:0]         o_segment_mm,
    input logic [47:0]         o_total_mm,
    input logic                o_total_saturated
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_mm))
        else $error("stalled result dropped or changed");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_saturated |-> o_total_mm == 48'(hts_pkg::TOTAL_MAX))
        else $error("saturated flag without maximum total");

    a_total_ge_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_total_saturated |-> o_total_mm >= 48'(o_segment_mm))
        else $error("total smaller than its last segment");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken without going busy");

endmodule

bind haversine_trip_distance hts_checker u_hts_checker (.*);

[tb/sv/trip_distance_checker.sv]
// Checker for the haversine trip distance block: predicts each segment and total and compares.
`timescale 1ns / 100ps
module trip_distance_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [22:0]        i_cfg_wdata,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic               i_trip_start,
    input  logic signed [30:0] i_lat_first,
    input  logic signed [31:0] i_lon_first,
    input  logic signed [30:0] i_lat_second,
    input  logic signed [31:0] i_lon_second,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [34:0]        i_segment_mm,
    input  logic [47:0]        i_total_mm,
    input  logic               i_total_saturated,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int            NITER     = hts_pkg::CORDIC_ITERATIONS;
    localparam longint        Q60_ONE   = 64'sd1 <<< 60;
    localparam longint unsigned PI_HALF_Q32 = 64'd6746518852;
    localparam longint unsigned BAM_SCALE   = 64'd2562047788;
    localparam logic [47:0]   TRIP_MAX  = '1;

    typedef struct {
        logic [34:0] seg;
        logic [47:0] total;
        logic        sat;
    } t_trip_result;

    longint        atan_tab [0:NITER-1];
    longint        cordic_gain;
    longint unsigned radius_m;
    logic [47:0]   trip_total;
    logic          trip_sat;
    t_trip_result  expected_q [$];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // atan(1/n) in Q62 by its alternating series
    function automatic longint unsigned atan_series(longint unsigned n);
        longint unsigned p, sum, k, term;
        p   = (64'd1 << 62) / n;
        sum = 0;
        k   = 0;
        while (p != 0) begin
            term = p / (2 * k + 1);
            if (k[0] == 1'b0) sum = sum + term;
            else sum = sum - term;
            p = p / n / n;
            k = k + 1;
        end
        return sum;
    endfunction

    initial begin
        longint unsigned k2, s;
        k2 = 64'd1 << 62;
        for (int i = 0; i < NITER; i++) begin
            if (i == 0) s = atan_series(2) + atan_series(3);
            else if (i < 62) s = atan_series(64'd1 << i);
            else s = 0;
            atan_tab[i] = longint'((s + (64'd1 << 31)) >> 32);
            if (i < 31) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
        end
        cordic_gain = longint'((root_floor(k2) + 1) >> 1);
    end

    function automatic logic [31:0] deg7_to_bam(longint v);
        longint unsigned m, r;
        m = (v < 0) ? longint'(-v) : v;
        r = (m * BAM_SCALE + (64'd1 << 31)) >> 32;
        return (v < 0) ? 32'(-r[31:0]) : r[31:0];
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint sn, output longint cs);
        logic [31:0]     turned, a2, neg_a2;
        logic            flip, neg;
        longint unsigned mag;
        longint          x, y, z, dx, dy;
        turned = ang + 32'h4000_0000;
        flip   = turned[31];
        a2     = flip ? ang + 32'h8000_0000 : ang;
        neg    = a2[31];
        neg_a2 = 32'd0 - a2;
        mag    = neg ? {32'd0, neg_a2} : {32'd0, a2};
        z      = longint'((mag * PI_HALF_Q32 + (64'd1 << 31)) >> 32);
        if (neg) z = -z;
        x = cordic_gain;
        y = 0;
        for (int i = 0; i < NITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        sn = y;
        cs = x;
    endtask

    // atan2(y, x) for x, y >= 0 by vectoring, Q30 radians
    function automatic longint half_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        if (y == 0) return 0;
        for (int i = 0; i < NITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    task automatic predict_segment(input logic start, input longint lat_a, input longint lon_a,
                                   input longint lat_b, input longint lon_b);
        longint          s1, s2, ca, cb, tmp, t, u, a, half;
        longint unsigned seg_full;
        t_trip_result    r;
        rotate(deg7_to_bam(lat_b - lat_a), s1, tmp);
        rotate(deg7_to_bam(lon_b - lon_a), s2, tmp);
        rotate(deg7_to_bam(2 * lat_a), tmp, ca);
        rotate(deg7_to_bam(2 * lat_b), tmp, cb);
        t = round_q30(s2 * ca);
        u = round_q30(s2 * cb);
        a = s1 * s1 + t * u;
        if (a < 0) a = 0;
        if (a > Q60_ONE) a = Q60_ONE;
        half = half_angle(longint'(root_floor(Q60_ONE - a)), longint'(root_floor(a)));
        seg_full = ((radius_m * 1000) * longint'(half) + (64'd1 << 28)) >> 29;
        r.seg = seg_full[34:0];
        if (start) begin
            trip_total = '0;
            trip_sat   = 1'b0;
        end
        if ({13'd0, r.seg} >= TRIP_MAX - trip_total) begin
            trip_total = TRIP_MAX;
            trip_sat   = 1'b1;
        end else begin
            trip_total = trip_total + {13'd0, r.seg};
        end
        r.total = trip_total;
        r.sat   = trip_sat;
        expected_q.push_back(r);
    endtask

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_trip_result r;
        if (!i_rst_n) begin
            radius_m   = hts_pkg::RADIUS_RESET;
            trip_total = '0;
            trip_sat   = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) radius_m = i_cfg_wdata;
            if (i_valid && !i_in_stall)
                predict_segment(i_trip_start, i_lat_first, i_lon_first,
                                i_lat_second, i_lon_second);
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transfer, segment_mm", i_segment_mm, 0);
                end else begin
                    r = expected_q.pop_front();
                    if (i_segment_mm !== r.seg) report("segment_mm", i_segment_mm, r.seg);
                    if (i_total_mm !== r.total) report("total_mm", i_total_mm, r.total);
                    if (i_total_saturated !== r.sat)
                        report("total_saturated", i_total_saturated, r.sat);
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

[tb/sv/haversine_trip_distance_tb.sv]
// Testbench top for the haversine trip distance block: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module haversine_trip_distance_tb;

    localparam logic [22:0] RADIUS_MAX = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [22:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_trip_start = 1'b0;
    logic signed [30:0] i_lat_first = '0;
    logic signed [31:0] i_lon_first = '0;
    logic signed [30:0] i_lat_second = '0;
    logic signed [31:0] i_lon_second = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [34:0]        o_segment_mm;
    logic [47:0]        o_total_mm;
    logic               o_total_saturated;
    int                 fail_count;
    int                 pending;
    bit                 gaps_on = 1'b0;
    int                 stall_hold = 0;

    haversine_trip_distance dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid, .o_stall,
        .i_trip_start, .i_lat_first, .i_lon_first, .i_lat_second, .i_lon_second,
        .o_valid, .i_stall, .o_segment_mm, .o_total_mm, .o_total_saturated
    );

    trip_distance_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid,
        .i_in_stall(o_stall), .i_trip_start, .i_lat_first, .i_lon_first,
        .i_lat_second, .i_lon_second, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_segment_mm(o_segment_mm), .i_total_mm(o_total_mm),
        .i_total_saturated(o_total_saturated), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stall: mostly short bursts, now and then a long hold
    always @(negedge i_clk) begin
        int r;
        if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                i_stall = 1'b1; stall_hold = $urandom_range(20, 120);
            end else if (r < 30) begin
                i_stall = 1'b1; stall_hold = $urandom_range(0, 3);
            end else if (r < 40) begin
                i_stall = 1'b0; stall_hold = $urandom_range(50, 300);
            end else begin
                i_stall = 1'b0; stall_hold = $urandom_range(0, 20);
            end
        end
    end

    task automatic send_fixes(input logic start, input longint lat_a, input longint lon_a,
                              input longint lat_b, input longint lon_b);
        int r, n;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            n = (r < 50) ? 0 : (r < 96) ? $urandom_range(1, 4) : $urandom_range(30, 150);
            if (n > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_trip_start = start;
        i_lat_first  = lat_a[30:0];
        i_lon_first  = lon_a[31:0];
        i_lat_second = lat_b[30:0];
        i_lon_second = lon_b[31:0];
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [22:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(0, 1800000000)) - 900000000;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    endfunction

    task automatic send_random();
        int     mode;
        logic   start;
        longint la, lo, d;
        mode  = $urandom_range(0, 9);
        start = ($urandom_range(0, 19) == 0);
        if (mode < 7) begin
            // consecutive fixes close together
            la = rand_lat();
            lo = rand_lon();
            d  = longint'($urandom_range(0, 20000000)) - 10000000;
            d  = d >>> $urandom_range(0, 16);
            send_fixes(start, la, lo, la + d,
                       lo + ((longint'($urandom_range(0, 20000000)) - 10000000)
                             >>> $urandom_range(0, 16)));
        end else if (mode < 9) begin
            send_fixes(start, rand_lat(), rand_lon(), rand_lat(), rand_lon());
        end else begin
            send_fixes(start, longint'(signed'(31'($urandom))), longint'(signed'($urandom)),
                       longint'(signed'(31'($urandom))), longint'(signed'($urandom)));
        end
    endtask

    initial begin
        #150_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        longint lo;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero length, poles, date line, antipodes, raw extremes
        send_fixes(1'b1, 0, 0, 0, 0);
        send_fixes(1'b0, 515000000, -1200000, 515000000, -1200000);
        send_fixes(1'b0, 900000000, 0, -900000000, 0);
        send_fixes(1'b0, -900000000, 1800000000, 900000000, -1800000000);
        send_fixes(1'b0, 0, 1799999999, 0, -1799999999);
        send_fixes(1'b0, 0, 0, 0, 1800000000);
        send_fixes(1'b0, 0, -1800000000, 0, 1800000000);
        send_fixes(1'b0, 900000000, 123, 900000000, -456);
        send_fixes(1'b1, 450000000, 0, -450000000, 1800000000);
        send_fixes(1'b0, 1073741823, 2147483647, -1073741824, -64'sd2147483648);
        send_fixes(1'b0, -1073741824, -64'sd2147483648, 1073741823, 2147483647);
        send_fixes(1'b0, 1, 0, 0, 1);
        send_fixes(1'b0, -1, -1, 0, 0);
        write_radius(23'd0);
        send_fixes(1'b0, 0, 0, 0, 1800000000);
        send_fixes(1'b1, 100000000, 200000000, -300000000, -400000000);
        write_radius(23'd6300000);
        send_fixes(1'b0, 0, 0, 0, 1800000000);
        write_radius(23'd6400000);
        send_fixes(1'b0, 0, 0, 0, 1800000000);

        // largest radius with antipodal segments, the longest the block can see
        write_radius(RADIUS_MAX);
        send_fixes(1'b1, 0, 0, 0, 1800000000);
        for (int i = 0; i < 24; i++) begin
            lo = -longint'($urandom_range(0, 1800000000));
            send_fixes(1'b0, 0, lo, 0, lo + 1800000000);
        end
        send_fixes(1'b0, 0, 0, 0, 0);
        send_fixes(1'b1, 0, 0, 0, 1800000000);

        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase)
                0: write_radius(hts_pkg::RADIUS_RESET);
                1: write_radius(23'd6300000);
                2: write_radius(23'd6400000);
                3: write_radius(23'($urandom));
                default: write_radius(23'($urandom_range(6300000, 6400000)));
            endcase
            for (int i = 0; i < 250; i++) begin
                if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
                send_random();
            end
        end

        gaps_on = 1'b0;
        drain_results();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
